// ----- design/ppc_pkg.sv -----
// ----------------------------------------------------------------------------
// Premultiplied pixel compositor package
// Shared payload types, operator codes and the rounded byte-product helper.
// ----------------------------------------------------------------------------
`default_nettype none

package ppc_pkg;

  // Operator codes of the blend operator register.
  typedef enum logic [1:0] {
    BLEND_SRC      = 2'd0,
    BLEND_SRC_OVER = 2'd1,
    BLEND_DST_IN   = 2'd2,
    BLEND_DST_OUT  = 2'd3
  } blend_op_e;

  // Configuration register indexes and port widths.
  localparam int unsigned CfgIdxWidth  = 1;
  localparam int unsigned CfgDataWidth = 2;
  localparam logic [CfgIdxWidth-1:0] CFG_BLEND_OP  = 1'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_SOLID_SRC = 1'd1;

  localparam logic [7:0] FullCoverage = 8'hff;

  // One input request.
  typedef struct packed {
    logic [31:0] src_pixel;
    logic [31:0] dst_pixel;
    logic [7:0]  coverage;
    logic        span_last;
  } pix_req_t;

  // One result.
  typedef struct packed {
    logic [31:0] out_pixel;
    logic        out_span_last;
  } pix_res_t;

  // Hand-over between the front and back halves: the result is
  // base + dst * factor, with the product rounded per byte.
  typedef struct packed {
    logic [31:0] base;
    logic [7:0]  factor;
    logic [31:0] dst;
    logic        last;
  } ppc_mid_t;

  // Load enables for the two register stages inside one half.
  typedef struct packed {
    logic first;
    logic second;
  } ppc_en_t;

  // Rounded division by 255 of a byte product (or a sum of two products
  // whose weights add up to 255): (v + (v >> 8) + 0x80) >> 8.
  function automatic logic [7:0] fix8(input logic [15:0] v);
    logic [15:0] t;
    t = v + {8'd0, v[15:8]} + 16'd128;
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

// ----- design/ppc_front.sv -----
// ----------------------------------------------------------------------------
// Compositor front half
// Forms the coverage products, then the base term and the destination factor.
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_front
  import ppc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire ppc_en_t   en_i,
  input  wire pix_req_t  req_i,
  input  wire blend_op_e op_i,
  input  wire logic      solid_i,
  output ppc_mid_t       mid_o
);

  // Stage one: raw byte products.
  logic [3:0][15:0] src_prod_d, src_prod_q;
  logic [3:0][15:0] dst_prod_d, dst_prod_q;
  logic [15:0]      alpha_prod_d, alpha_prod_q;
  logic [7:0]       icov_d, icov_q;
  logic [7:0]       alpha_sel_d, alpha_sel_q;
  logic [31:0]      src_q, dst_q;
  logic             full_q, solid_q, last_q;
  blend_op_e        op_q;

  // Stage two: base term and factor.
  ppc_mid_t         mid_d, mid_q;

  logic [31:0] s_pix, dsti_pix, lerp_pix;
  logic [7:0]  f_cov;

  always_comb begin
    icov_d = FullCoverage - req_i.coverage;
    alpha_sel_d = (op_i == BLEND_DST_OUT) ? (FullCoverage - req_i.src_pixel[31:24])
                                          : req_i.src_pixel[31:24];
    for (int i = 0; i < 4; i++) begin
      src_prod_d[i] = {8'd0, req_i.src_pixel[8*i +: 8]} * {8'd0, req_i.coverage};
      dst_prod_d[i] = {8'd0, req_i.dst_pixel[8*i +: 8]} * {8'd0, icov_d};
    end
    alpha_prod_d = {8'd0, alpha_sel_d} * {8'd0, req_i.coverage};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.first) begin
      src_prod_q   <= src_prod_d;
      dst_prod_q   <= dst_prod_d;
      alpha_prod_q <= alpha_prod_d;
      icov_q       <= icov_d;
      alpha_sel_q  <= alpha_sel_d;
      src_q        <= req_i.src_pixel;
      dst_q        <= req_i.dst_pixel;
      full_q       <= (req_i.coverage == FullCoverage);
      solid_q      <= solid_i;
      last_q       <= req_i.span_last;
      op_q         <= op_i;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s_pix[8*i +: 8]    = fix8(src_prod_q[i]);
      dsti_pix[8*i +: 8] = fix8(dst_prod_q[i]);
      lerp_pix[8*i +: 8] = fix8(src_prod_q[i] + dst_prod_q[i]);
    end
    // The scaled factor never exceeds 255, so eight bits hold it.
    f_cov = fix8(alpha_prod_q) + icov_q;

    mid_d.dst  = dst_q;
    mid_d.last = last_q;
    unique case (op_q)
      BLEND_SRC: begin
        mid_d.factor = 8'd0;
        if (full_q) begin
          mid_d.base = src_q;
        end else if (solid_q) begin
          mid_d.base = s_pix + dsti_pix;
        end else begin
          mid_d.base = lerp_pix;
        end
      end
      BLEND_SRC_OVER: begin
        // An opaque source gives a zero factor and a zero source a factor
        // of 255, which reproduce the copy and pass-through shortcuts.
        mid_d.base   = full_q ? src_q : s_pix;
        mid_d.factor = FullCoverage - (full_q ? src_q[31:24] : s_pix[31:24]);
      end
      default: begin
        mid_d.base   = 32'd0;
        mid_d.factor = full_q ? alpha_sel_q : f_cov;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.second) begin
      mid_q <= mid_d;
    end
  end

  assign mid_o = mid_q;

endmodule

`default_nettype wire

// ----- design/ppc_back.sv -----
// ----------------------------------------------------------------------------
// Compositor back half
// Scales the destination by the factor and adds the base term.
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_back
  import ppc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire ppc_en_t  en_i,
  input  wire ppc_mid_t mid_i,
  output pix_res_t      res_o
);

  logic [3:0][15:0] prod_d, prod_q;
  logic [31:0]      base_q;
  logic             last_q;
  logic [31:0]      scaled;
  pix_res_t         res_d, res_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_d[i] = {8'd0, mid_i.dst[8*i +: 8]} * {8'd0, mid_i.factor};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.first) begin
      prod_q <= prod_d;
      base_q <= mid_i.base;
      last_q <= mid_i.last;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      scaled[8*i +: 8] = fix8(prod_q[i]);
    end
    // Plain 32-bit add: a lane that overflows carries into its neighbour.
    res_d.out_pixel     = base_q + scaled;
    res_d.out_span_last = last_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.second) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ----- design/premultiplied_pixel_compositor.sv -----
// ----------------------------------------------------------------------------
// Premultiplied pixel compositor
// Porter-Duff blending of premultiplied ARGB8888 pixels under coverage.
// ----------------------------------------------------------------------------
// The compositor takes one request per clock when the output side is not
// stalled and returns its blended pixel from the last of four register
// stages (coverage products, base and factor, destination products,
// rounding and final add); while the output moves, a new request can enter
// in every cycle. Requests flow through a valid-tagged pipeline in
// which each stage loads whenever it is empty or the stage after it moves,
// so bubbles are squeezed out and the input stays ready while a finished
// result waits at the output, until every stage behind it holds a request.
// The operator and the solid-source flag are sampled as a request enters,
// and must only be written while the pipeline holds no requests. Every
// operator is reduced to base + dst * factor with per-byte rounded products,
// so the source-over shortcuts for opaque and zero sources need no separate
// path.
// ----------------------------------------------------------------------------
`default_nettype none

module premultiplied_pixel_compositor
  import ppc_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,

  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire pix_req_t                in_req_i,

  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output pix_res_t                     out_res_o,

  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i
);

  // Configuration registers.
  blend_op_e blend_op_q;
  logic      solid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_op_q <= BLEND_SRC_OVER;
      solid_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BLEND_OP:  blend_op_q <= blend_op_e'(cfg_data_i);
        CFG_SOLID_SRC: solid_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Valid bits of the four stages; the last one is the output register.
  logic [3:0] valid_q;
  logic [3:0] stage_en;

  // A stage may load when it is empty or its contents move on this cycle.
  always_comb begin
    stage_en[3] = !valid_q[3] || out_ready_i;
    stage_en[2] = !valid_q[2] || stage_en[3];
    stage_en[1] = !valid_q[1] || stage_en[2];
    stage_en[0] = !valid_q[0] || stage_en[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 4'd0;
    end else begin
      if (stage_en[0]) valid_q[0] <= in_valid_i;
      if (stage_en[1]) valid_q[1] <= valid_q[0];
      if (stage_en[2]) valid_q[2] <= valid_q[1];
      if (stage_en[3]) valid_q[3] <= valid_q[2];
    end
  end

  assign in_ready_o  = stage_en[0];
  assign out_valid_o = valid_q[3];

  ppc_en_t  front_en, back_en;
  ppc_mid_t mid;

  assign front_en = '{first: stage_en[0], second: stage_en[1]};
  assign back_en  = '{first: stage_en[2], second: stage_en[3]};

  ppc_front u_front (
    .clk_i   (clk_i),
    .en_i    (front_en),
    .req_i   (in_req_i),
    .op_i    (blend_op_q),
    .solid_i (solid_q),
    .mid_o   (mid)
  );

  ppc_back u_back (
    .clk_i (clk_i),
    .en_i  (back_en),
    .mid_i (mid),
    .res_o (out_res_o)
  );

endmodule

`default_nettype wire
